/* src/int_to_ascii_converter_top_macros.svh */
// Assertion macros used by the checks in the converter's top level.
`ifndef INT_TO_ASCII_CONVERTER_TOP_MACROS_SVH
`define INT_TO_ASCII_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define ITAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define ITAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/itac_pkg.sv */
// Shared types, character codes and helpers of the integer-to-ASCII converter.
package itac_pkg;

	localparam logic [6:0] CHAR_MINUS = 7'h2d;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [3:0] DIGIT_TEN  = 4'd10;

	typedef struct packed {
		logic neg;
		logic hex;
	} item_flags_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SKIP  = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_DIGIT = 5'b10000
	} back_state_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [3:0] ofs;
		ofs = d - DIGIT_TEN;
		if (d < DIGIT_TEN) begin
			return CHAR_ZERO + {3'b000, d};
		end
		return CHAR_LOWER_A + {3'b000, ofs};
	endfunction

endpackage

/* src/int_to_ascii_converter_top.sv */
// Top level of the integer-to-ASCII converter: stream ports, front end, back end, checks.
`include "int_to_ascii_converter_top_macros.svh"

// Converts one signed VALUE_WIDTH-bit integer per input transfer into its text, one ASCII
// character per output transfer, most significant digit first, with tlast on the final
// character. tuser[0] selects base sixteen (lower-case a-f) over base ten. Negative values
// give '-' and then the digits of the magnitude; the most negative value converts correctly;
// zero gives a single '0'. Steps per item: a load from the queue, then for base ten the
// shift-add-3 loop of the back end over every bit of the value, then a scan down the digit
// register past the leading zero digits, then the characters, each held while the output
// stalls. A base-sixteen item skips the shift loop. For base ten the shift-add-3 loop sets
// the rate; the back end takes no new item until the last character of the current one is
// loaded into the output register. A two-entry queue sits between the front end and the
// back end, so up to two further items are taken while one is being converted, and the
// output register lets conversion move on while a character waits.
module int_to_ascii_converter_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // value
	input  logic [0:0]                              s_axis_tuser,  // hex_mode
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [7:0]                              m_axis_tdata,  // char_code
	output logic                                    m_axis_tlast   // last
);

	logic [VALUE_WIDTH-1:0]  q_mag;
	itac_pkg::item_flags_t   q_flags;
	logic                    q_valid;
	logic                    q_ready;
	logic                    back_busy;
	logic [6:0]              out_char;

	// classify and queue; upper pad bits of tdata are ignored
	itac_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_value (s_axis_tdata[VALUE_WIDTH-1:0]),
		.in_hex   (s_axis_tuser[0]),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_mag    (q_mag),
		.q_flags  (q_flags)
	);

	// convert and emit characters through the output register
	itac_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_mag     (q_mag),
		.q_flags   (q_flags),
		.busy      (back_busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	// pad the 7-bit code to a whole byte
	assign m_axis_tdata = {1'b0, out_char};

	// a full queue is never empty
	`ITAC_ASSERT_NOW(a_full_not_empty, !s_axis_tready, q_valid, "queue full yet empty")
	// a popped item always starts a conversion
	`ITAC_ASSERT_NEXT(a_pop_starts_work, q_valid && q_ready, back_busy, "pop did not start work")
	// the minus sign is never the final character
	`ITAC_ASSERT_NOW(a_minus_not_last, m_axis_tvalid && m_axis_tlast,
		m_axis_tdata[6:0] != itac_pkg::CHAR_MINUS, "minus sign flagged last")

endmodule

/* src/itac_front.sv */
// Front end: accept items, form sign and magnitude, hold them in a two-entry queue.
module itac_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [VALUE_WIDTH-1:0]    in_value,
	input  logic                      in_hex,
	output logic                      q_valid,
	input  logic                      q_ready,
	output logic [VALUE_WIDTH-1:0]    q_mag,
	output itac_pkg::item_flags_t     q_flags
);

	logic [VALUE_WIDTH-1:0]  mag;
	itac_pkg::item_flags_t   flags;
	logic [VALUE_WIDTH-1:0]  mag_q [2];
	itac_pkg::item_flags_t   flags_q [2];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              count_q;
	logic                    push;
	logic                    pop;

	// unsigned magnitude: the most negative value maps onto itself, which is correct
	assign flags.neg = in_value[VALUE_WIDTH-1];
	assign flags.hex = in_hex;
	assign mag = flags.neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_mag    = mag_q[rd_ptr_q];
	assign q_flags  = flags_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mag_q[wr_ptr_q]   <= mag;
			flags_q[wr_ptr_q] <= flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* src/itac_back.sv */
// Back end: shift-add-3 binary to BCD, leading-zero skip and character emission.
module itac_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  logic [VALUE_WIDTH-1:0]    q_mag,
	input  itac_pkg::item_flags_t     q_flags,
	output logic                      busy,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [6:0]                out_char,
	output logic                      out_last
);

	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int BCD_W      = NDIG * 4;
	localparam int PTR_W      = $clog2(NDIG);
	localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

	itac_pkg::back_state_t   state_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [BCD_W-1:0]        bcd_adj;
	logic [VALUE_WIDTH-1:0]  shift_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [PTR_W-1:0]        ptr_q;
	logic                    neg_q;
	logic                    out_valid_q;
	logic [6:0]              out_char_q;
	logic                    out_last_q;
	logic [3:0]              cur_digit;
	logic                    slot_free;
	logic                    emit;

	// add 3 to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign cur_digit = bcd_q[{ptr_q, 2'b00} +: 4];
	assign slot_free = !out_valid_q || out_ready;
	// a character is loaded into the output register this cycle
	assign emit      = slot_free &&
		(state_q == itac_pkg::ST_SIGN || state_q == itac_pkg::ST_DIGIT);
	assign q_ready   = (state_q == itac_pkg::ST_IDLE);
	assign busy      = (state_q != itac_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itac_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bcd_q       <= '0;
			shift_q     <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			neg_q       <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				itac_pkg::ST_IDLE: begin
					if (q_valid) begin
						neg_q <= q_flags.neg;
						ptr_q <= PTR_W'(NDIG - 1);
						if (q_flags.hex) begin
							bcd_q   <= BCD_W'(q_mag);
							state_q <= itac_pkg::ST_SKIP;
						end else begin
							bcd_q   <= '0;
							shift_q <= q_mag;
							cnt_q   <= CNT_W'(VALUE_WIDTH);
							state_q <= itac_pkg::ST_CONV;
						end
					end
				end
				itac_pkg::ST_CONV: begin
					bcd_q   <= {bcd_adj[BCD_W-2:0], shift_q[VALUE_WIDTH-1]};
					shift_q <= {shift_q[VALUE_WIDTH-2:0], 1'b0};
					cnt_q   <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= itac_pkg::ST_SKIP;
					end
				end
				itac_pkg::ST_SKIP: begin
					if (cur_digit == 4'd0 && ptr_q != '0) begin
						ptr_q <= ptr_q - PTR_W'(1);
					end else if (neg_q) begin
						state_q <= itac_pkg::ST_SIGN;
					end else begin
						state_q <= itac_pkg::ST_DIGIT;
					end
				end
				itac_pkg::ST_SIGN: begin
					if (slot_free) begin
						out_char_q  <= itac_pkg::CHAR_MINUS;
						out_last_q  <= 1'b0;
						state_q     <= itac_pkg::ST_DIGIT;
					end
				end
				itac_pkg::ST_DIGIT: begin
					if (slot_free) begin
						out_char_q  <= itac_pkg::digit_char(cur_digit);
						out_last_q  <= (ptr_q == '0);
						if (ptr_q == '0) begin
							state_q <= itac_pkg::ST_IDLE;
						end else begin
							ptr_q <= ptr_q - PTR_W'(1);
						end
					end
				end
				default: begin
					state_q <= itac_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* dv/itac_text_checker.sv */
// Checker for the integer-to-ASCII converter: predicts the text of each number and compares.
module itac_text_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	input  logic                                    s_axis_tready,
	input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // value
	input  logic [0:0]                              s_axis_tuser,  // hex_mode
	input  logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	input  logic [7:0]                              m_axis_tdata,  // char_code
	input  logic                                    m_axis_tlast,  // last
	output int                                      chars_pending,
	output int                                      fail_count
);

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} text_char_t;

	text_char_t text_due[$];

	// Append the characters of one number, most significant digit first.
	function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value, input logic hex);
		logic [VALUE_WIDTH-1:0] mag;
		logic [VALUE_WIDTH-1:0] radix;
		logic [3:0]             digits[$];
		logic [3:0]             d;
		text_char_t             c;
		if (value == '0) begin
			c.code = itac_pkg::CHAR_ZERO;
			c.last = 1'b1;
			text_due.push_back(c);
			return;
		end
		// two's complement magnitude, taken unsigned so the most negative value survives
		mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
		radix = hex ? VALUE_WIDTH'(16) : VALUE_WIDTH'(10);
		while (mag != '0) begin
			digits.push_front(4'(mag % radix));
			mag = mag / radix;
		end
		if (value[VALUE_WIDTH-1]) begin
			c.code = itac_pkg::CHAR_MINUS;
			c.last = 1'b0;
			text_due.push_back(c);
		end
		for (int i = 0; i < digits.size(); i++) begin
			d = digits[i];
			c.code = (d < 4'd10) ? itac_pkg::CHAR_ZERO + {3'b000, d}
				: itac_pkg::CHAR_LOWER_A + {3'b000, d - 4'd10};
			c.last = (i == digits.size() - 1);
			text_due.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			// check the outgoing character before queuing anything from this edge's input
			if (m_axis_tvalid && m_axis_tready) begin
				if (text_due.size() == 0) begin
					$display("%0t: unexpected character: expected none, got tdata %02h tlast %0b",
						$time, m_axis_tdata, m_axis_tlast);
					fail_count <= fail_count + 1;
				end else begin
					want = text_due.pop_front();
					if (m_axis_tdata !== {1'b0, want.code} || m_axis_tlast !== want.last) begin
						$display("%0t: mismatch: expected tdata %02h tlast %0b, got %02h %0b",
							$time, {1'b0, want.code}, want.last, m_axis_tdata, m_axis_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_text(s_axis_tdata[VALUE_WIDTH-1:0], s_axis_tuser[0]);
			chars_pending <= text_due.size();
		end
	end

endmodule

/* dv/testbench.sv */
// Top of the integer-to-ASCII converter testbench: clock, reset, stimulus and verdict.
module testbench;
	localparam int VALUE_WIDTH = 32;
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off, enough to back up the input

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;     // value
	logic [0:0]  s_axis_tuser = '0;     // hex_mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // char_code
	logic        m_axis_tlast;          // last

	int chars_pending;
	int fail_count;

	// idle odds in percent, changed by the stimulus between phases
	int send_idle_pct = 8;
	int recv_idle_pct = 57;

	// hold-off requests: the stimulus bumps the request count, the receiver serves them
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	int_to_ascii_converter_top #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	itac_text_checker #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.chars_pending(chars_pending),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: a pending hold-off request wins over random stalling.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_served != hold_requests) begin
				m_axis_tready <= 1'b0;
				hold_served <= hold_served + 1;
				hold_left <= HOLD_CYCLES;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one number and hold it until the transfer happens.
	// tvalid stays high on return so back-to-back numbers leave no gap.
	task automatic offer_number(input logic [31:0] value, input logic hex);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= hex;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Drop tvalid and wait until every predicted character has come out.
	// The first edge lets the checker count the number just transferred.
	task automatic wait_text_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0)
			@(posedge clk);
	endtask

	// Values near a digit-count boundary in the chosen base, either sign.
	function automatic logic [31:0] near_boundary(input logic hex);
		logic [31:0] p;
		logic [31:0] v;
		p = 32'd1;
		if (hex)
			p = 32'd1 << (4 * $urandom_range(7));
		else
			repeat ($urandom_range(9)) p = p * 32'd10;
		v = p + 32'($urandom_range(2)) - 32'd1;
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic logic [31:0] random_value(input logic hex);
		int unsigned pick;
		logic [31:0] v;
		pick = $urandom_range(99);
		if (pick < 40) begin
			v = $urandom;
		end else if (pick < 60) begin
			v = 32'($urandom_range(999));
			if ($urandom_range(1))
				v = -v;
		end else if (pick < 75) begin
			v = near_boundary(hex);
		end else if (pick < 90) begin
			v = {1'b1, 31'($urandom)};
		end else begin
			case ($urandom_range(3))
				0: v = 32'h0000_0000;
				1: v = 32'hffff_ffff;
				2: v = 32'h8000_0000;
				default: v = 32'h7fff_ffff;
			endcase
		end
		return v;
	endfunction

	task automatic offer_random(input int count);
		logic hex;
		repeat (count) begin
			hex = 1'($urandom_range(1));
			offer_number(random_value(hex), hex);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, unit values, extremes, digit-count boundaries, all hex letters
		offer_number(32'd0, 1'b0);
		offer_number(32'd0, 1'b1);
		offer_number(32'd1, 1'b0);
		offer_number(32'd1, 1'b1);
		offer_number(32'hffff_ffff, 1'b0);
		offer_number(32'hffff_ffff, 1'b1);
		offer_number(32'd9, 1'b0);
		offer_number(32'd10, 1'b0);
		offer_number(32'd15, 1'b1);
		offer_number(32'd16, 1'b1);
		offer_number(32'h7fff_ffff, 1'b0);
		offer_number(32'h7fff_ffff, 1'b1);
		offer_number(32'h8000_0000, 1'b0);
		offer_number(32'h8000_0000, 1'b1);
		offer_number(32'h8000_0001, 1'b0);
		offer_number(32'd1000000000, 1'b0);
		offer_number(-32'd1000000000, 1'b0);
		offer_number(32'd999999999, 1'b0);
		offer_number(-32'd100, 1'b0);
		offer_number(32'h0abc_def9, 1'b1);
		offer_number(32'hfedc_ba98, 1'b1);
		offer_number(32'h0000_00ff, 1'b1);
		wait_text_drained();

		// phase 1: sender rarely idles, receiver often stalls
		offer_random(100);
		// long receiver hold-off while numbers keep coming, so the input backs up
		hold_requests <= hold_requests + 1;
		offer_random(20);
		wait_text_drained();

		// phase 2: swap the idle odds
		send_idle_pct = 57;
		recv_idle_pct = 8;
		offer_random(120);
		wait_text_drained();

		// phase 3: no idling on either side, one more hold-off at full rate
		send_idle_pct = 0;
		recv_idle_pct = 0;
		offer_random(60);
		hold_requests <= hold_requests + 1;
		offer_random(60);

		wait_text_drained();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
